>>> rtl/cartridge_bank_controller_top_assert.svh
// Assertion macros for the cartridge bank controller checker
`ifndef CARTRIDGE_BANK_CONTROLLER_TOP_ASSERT_SVH
`define CARTRIDGE_BANK_CONTROLLER_TOP_ASSERT_SVH

// same-cycle implication, sampled on aclk, off during reset
`define CBC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off during reset
`define CBC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/cbc_pkg.sv
// Types, constants and helper functions shared by the cartridge bank controller
`default_nettype none

package cbc_pkg;

    localparam int ADDR_W     = 16;
    localparam int BYTE_W     = 8;
    localparam int ROM_ADDR_W = 21;
    localparam int ROM_BANK_W = 7;
    localparam int ROM_OFF_W  = 14;
    localparam int RAM_BANK_W = 2;
    localparam int RAM_OFF_W  = 13;
    localparam int RAM_AW     = RAM_BANK_W + RAM_OFF_W;
    localparam int RAM_DEPTH  = 1 << RAM_AW;
    localparam int LOW_BANK_W = 5;

    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 32;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [ROM_BANK_W-1:0] ROM_BANK_MASK_RST = 7'h7F;
    localparam logic [RAM_BANK_W-1:0] RAM_BANK_MASK_RST = 2'h3;
    localparam logic [ROM_BANK_W-1:0] ROM_BANK_RST      = 7'h01;

    localparam logic [3:0]        RAM_ENABLE_CODE = 4'hA;
    localparam logic [BYTE_W-1:0] RAM_OFF_DATA    = 8'hFF;
    localparam logic [BYTE_W-1:0] MODE_SEL_ROM    = 8'h00;
    localparam logic [BYTE_W-1:0] MODE_SEL_RAM    = 8'h01;

    typedef enum logic [1:0] {
        KIND_WRITE    = 2'd0,
        KIND_ROM      = 2'd1,
        KIND_DATA     = 2'd2,
        KIND_UNMAPPED = 2'd3
    } kind_t;

    typedef enum logic {
        ACT_READ  = 1'b0,
        ACT_WRITE = 1'b1
    } action_t;

    typedef enum logic {
        MODE_ROM = 1'b0,
        MODE_RAM = 1'b1
    } mode_t;

    typedef enum logic {
        CFG_ROM_MASK = 1'b0,
        CFG_RAM_MASK = 1'b1
    } cfg_reg_t;

    // 8 KiB windows of the bus, selected by address bits 15:13
    typedef enum logic [2:0] {
        RGN_RAMG  = 3'd0,
        RGN_BANK1 = 3'd1,
        RGN_BANK2 = 3'd2,
        RGN_MODE  = 3'd3,
        RGN_VRAM  = 3'd4,
        RGN_XRAM  = 3'd5,
        RGN_WRAM  = 3'd6,
        RGN_HIGH  = 3'd7
    } region_t;

    // step over banks whose low five bits are zero, then apply the mask
    function automatic logic [ROM_BANK_W-1:0] skip_and_mask(
        input logic [ROM_BANK_W-1:0] bank,
        input logic [ROM_BANK_W-1:0] mask
    );
        logic [ROM_BANK_W-1:0] adj;
        adj = bank;
        if (bank[LOW_BANK_W-1:0] == '0) begin
            adj = bank + ROM_BANK_W'(1);
        end
        return adj & mask;
    endfunction

endpackage

`default_nettype wire

>>> rtl/cartridge_bank_controller_top.sv
// Cartridge bank controller: bank registers, cartridge RAM and access pipeline
`default_nettype none

// Takes one bus access word per cycle unless the result side stalls, and returns one
// result word per access, in order, through a stage register and an output register.
// The stage register serves the registered read port of the 32 KiB cartridge RAM held
// inside the block; bank register updates and RAM writes take effect at the edge that
// accepts the write, so a following read sees them. RAM contents are undefined until
// written and need no clearing after reset. The user must write mask registers over
// the APB port only while no access is in flight; the block does not enforce this.
module cartridge_bank_controller_top (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // address [15:0], write_data [23:16]
    input  wire logic [cbc_pkg::S_TDATA_W-1:0] s_tdata,
    // action [0]
    input  wire logic [0:0]                    s_tuser,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // rom_address [20:0], read_data [28:21]
    output logic [cbc_pkg::M_TDATA_W-1:0]      m_tdata,
    // kind [1:0]
    output logic [1:0]                         m_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [cbc_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [cbc_pkg::PDATA_W-1:0]   pwdata,
    output logic [cbc_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready
);
    import cbc_pkg::*;

    logic [ROM_BANK_W-1:0] rom_mask_reg;
    logic [RAM_BANK_W-1:0] ram_mask_reg;
    logic                  cfg_we;

    logic                  ram_en_reg,    ram_en_next;
    mode_t                 mode_reg,      mode_next;
    logic [ROM_BANK_W-1:0] rom_bank_reg,  rom_bank_next;
    logic [RAM_BANK_W-1:0] upper_reg,     upper_next;
    logic [RAM_BANK_W-1:0] ram_bank_reg,  ram_bank_next;

    logic                  accept;
    action_t               in_action;
    logic [ADDR_W-1:0]     in_addr;
    logic [BYTE_W-1:0]     in_wdata;
    region_t               in_rgn;

    logic [BYTE_W-1:0]     ram_mem [RAM_DEPTH];
    logic [RAM_AW-1:0]     ram_idx;
    logic                  ram_we;
    logic [BYTE_W-1:0]     ram_rdata_reg;

    kind_t                 st_kind_next;
    logic [ROM_ADDR_W-1:0] st_rom_next;
    logic                  st_valid_reg,  st_valid_next;
    kind_t                 st_kind_reg;
    logic [ROM_ADDR_W-1:0] st_rom_reg;
    logic                  st_ram_en_reg;
    logic                  st_adv;

    logic                  out_valid_reg, out_valid_next;
    kind_t                 out_kind_reg;
    logic [ROM_ADDR_W-1:0] out_rom_reg;
    logic [BYTE_W-1:0]     out_rdata_reg, out_rdata_next;

    // configuration port
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rom_mask_reg <= ROM_BANK_MASK_RST;
            ram_mask_reg <= RAM_BANK_MASK_RST;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(paddr[2]))
                CFG_ROM_MASK: rom_mask_reg <= pwdata[ROM_BANK_W-1:0];
                CFG_RAM_MASK: ram_mask_reg <= pwdata[RAM_BANK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_reg_t'(paddr[2]))
            CFG_ROM_MASK: prdata = PDATA_W'(rom_mask_reg);
            CFG_RAM_MASK: prdata = PDATA_W'(ram_mask_reg);
            default:      prdata = '0;
        endcase
    end

    // input word
    assign in_action = action_t'(s_tuser[0]);
    assign in_addr   = s_tdata[ADDR_W-1:0];
    assign in_wdata  = s_tdata[ADDR_W+BYTE_W-1:ADDR_W];
    assign in_rgn    = region_t'(in_addr[ADDR_W-1:ADDR_W-3]);
    assign accept    = s_tvalid && s_tready;

    // bank registers
    always_comb begin
        ram_en_next   = ram_en_reg;
        mode_next     = mode_reg;
        rom_bank_next = rom_bank_reg;
        upper_next    = upper_reg;
        ram_bank_next = ram_bank_reg;
        if (accept && in_action == ACT_WRITE) begin
            unique case (in_rgn)
                RGN_RAMG: begin
                    ram_en_next = (in_wdata[3:0] == RAM_ENABLE_CODE);
                end
                RGN_BANK1: begin
                    if (mode_reg == MODE_ROM) begin
                        rom_bank_next = skip_and_mask(
                            {upper_reg, in_wdata[LOW_BANK_W-1:0]}, rom_mask_reg);
                    end else begin
                        rom_bank_next = skip_and_mask(
                            ROM_BANK_W'(in_wdata[LOW_BANK_W-1:0]), rom_mask_reg);
                    end
                end
                RGN_BANK2: begin
                    if (mode_reg == MODE_ROM) begin
                        upper_next    = in_wdata[RAM_BANK_W-1:0];
                        rom_bank_next = skip_and_mask(
                            {in_wdata[RAM_BANK_W-1:0], rom_bank_reg[LOW_BANK_W-1:0]},
                            rom_mask_reg);
                    end else begin
                        ram_bank_next = in_wdata[RAM_BANK_W-1:0] & ram_mask_reg;
                    end
                end
                RGN_MODE: begin
                    if (in_wdata == MODE_SEL_ROM) begin
                        mode_next = MODE_ROM;
                    end else if (in_wdata == MODE_SEL_RAM) begin
                        mode_next = MODE_RAM;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ram_en_reg   <= 1'b0;
            mode_reg     <= MODE_ROM;
            rom_bank_reg <= ROM_BANK_RST;
            upper_reg    <= '0;
            ram_bank_reg <= '0;
        end else begin
            ram_en_reg   <= ram_en_next;
            mode_reg     <= mode_next;
            rom_bank_reg <= rom_bank_next;
            upper_reg    <= upper_next;
            ram_bank_reg <= ram_bank_next;
        end
    end

    // cartridge RAM
    assign ram_idx = {(mode_reg == MODE_RAM) ? ram_bank_reg : RAM_BANK_W'(0),
                      in_addr[RAM_OFF_W-1:0]};
    assign ram_we  = accept && in_action == ACT_WRITE && in_rgn == RGN_XRAM && ram_en_reg;

    always_ff @(posedge aclk) begin
        if (ram_we) begin
            ram_mem[ram_idx] <= in_wdata;
        end
        if (accept) begin
            ram_rdata_reg <= ram_mem[ram_idx];
        end
    end

    // result decode
    always_comb begin
        st_kind_next = KIND_WRITE;
        st_rom_next  = '0;
        if (in_action == ACT_READ) begin
            case (in_rgn) inside
                RGN_RAMG, RGN_BANK1: begin
                    st_kind_next = KIND_ROM;
                    st_rom_next  = ROM_ADDR_W'(in_addr);
                end
                RGN_BANK2, RGN_MODE: begin
                    st_kind_next = KIND_ROM;
                    st_rom_next  = {rom_bank_reg, in_addr[ROM_OFF_W-1:0]};
                end
                RGN_XRAM: st_kind_next = KIND_DATA;
                default:  st_kind_next = KIND_UNMAPPED;
            endcase
        end
    end

    // pipeline control
    assign st_adv   = st_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !st_valid_reg || st_adv;

    always_comb begin
        st_valid_next  = st_valid_reg;
        out_valid_next = out_valid_reg;
        if (accept) begin
            st_valid_next = 1'b1;
        end else if (st_adv) begin
            st_valid_next = 1'b0;
        end
        if (st_adv) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_rdata_next = '0;
        if (st_kind_reg == KIND_DATA) begin
            out_rdata_next = st_ram_en_reg ? ram_rdata_reg : RAM_OFF_DATA;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            st_valid_reg  <= st_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st_kind_reg   <= st_kind_next;
            st_rom_reg    <= st_rom_next;
            st_ram_en_reg <= ram_en_reg;
        end
        if (st_adv) begin
            out_kind_reg  <= st_kind_reg;
            out_rom_reg   <= st_rom_reg;
            out_rdata_reg <= out_rdata_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {(M_TDATA_W-ROM_ADDR_W-BYTE_W)'(0), out_rdata_reg, out_rom_reg};

endmodule

`default_nettype wire

>>> rtl/cbc_checker.sv
// Port-level checker for the cartridge bank controller and its bind
`default_nettype none

`include "cartridge_bank_controller_top_assert.svh"

module cbc_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic [cbc_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic [1:0]                    m_tuser,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready
);
    import cbc_pkg::*;

    `CBC_ASSERT_NEXT(a_m_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result word changed while stalled")
    `CBC_ASSERT_NOW(a_write_clear, m_tvalid && m_tuser == KIND_WRITE, m_tdata == '0, "write result carries data")
    `CBC_ASSERT_NOW(a_unmapped_clear, m_tvalid && m_tuser == KIND_UNMAPPED, m_tdata == '0, "unmapped read carries data")
    `CBC_ASSERT_NOW(a_rom_no_byte, m_tvalid && m_tuser == KIND_ROM, m_tdata[M_TDATA_W-1:ROM_ADDR_W] == '0, "ROM read carries a data byte")
    `CBC_ASSERT_NOW(a_data_no_addr, m_tvalid && m_tuser == KIND_DATA, m_tdata[ROM_ADDR_W-1:0] == '0, "RAM read carries a ROM address")

endmodule

bind cartridge_bank_controller_top cbc_checker u_cbc_checker (.*);

`default_nettype wire

>>> tb/cartridge_bank_controller_top_tb.sv
// Self-checking testbench for the cartridge bank controller: bus access streams against a bank model
`timescale 1ns / 1ps

import cbc_pkg::*;

typedef struct {
    kind_t                  kind;
    logic [ROM_ADDR_W-1:0]  rom_addr;
    logic [BYTE_W-1:0]      rd_byte;
} bus_result_t;

class cartridge_shadow;
    logic [ROM_BANK_W-1:0] rom_mask;
    logic [RAM_BANK_W-1:0] ram_mask;
    logic                  ram_on;
    mode_t                 mode;
    logic [ROM_BANK_W-1:0] rom_bank;
    logic [1:0]            upper_bits;
    logic [RAM_BANK_W-1:0] ram_bank;
    logic [BYTE_W-1:0]     ram_bytes [RAM_DEPTH];
    bit                    ram_written [RAM_DEPTH];
    bus_result_t           pending [$];
    int                    errors;
    int                    kind_count [4];

    function new();
        rom_mask   = 7'h7F;
        ram_mask   = 2'h3;
        ram_on     = 1'b0;
        mode       = MODE_ROM;
        rom_bank   = 7'h01;
        upper_bits = 2'h0;
        ram_bank   = 2'h0;
        errors     = 0;
        foreach (ram_written[i]) ram_written[i] = 1'b0;
        foreach (kind_count[i]) kind_count[i] = 0;
    endfunction

    function void set_mask(cfg_reg_t idx, logic [PDATA_W-1:0] value);
        if (idx == CFG_ROM_MASK) begin
            rom_mask = value[ROM_BANK_W-1:0];
        end else begin
            ram_mask = value[RAM_BANK_W-1:0];
        end
    endfunction

    function logic [ROM_BANK_W-1:0] select_bank(logic [ROM_BANK_W-1:0] bank);
        logic [ROM_BANK_W-1:0] adj;
        adj = bank;
        if (bank[LOW_BANK_W-1:0] == '0) begin
            adj = bank + 7'd1;
        end
        return adj & rom_mask;
    endfunction

    function int ram_slot(logic [ADDR_W-1:0] addr);
        int bank;
        bank = (mode == MODE_RAM) ? int'(ram_bank) : 0;
        return bank * (1 << RAM_OFF_W) + int'(addr[RAM_OFF_W-1:0]);
    endfunction

    function bit read_is_safe(action_t act, logic [ADDR_W-1:0] addr);
        return !(act == ACT_READ && addr[15:13] == RGN_XRAM && ram_on
                 && !ram_written[ram_slot(addr)]);
    endfunction

    function void mismatch(string what);
        errors++;
        if (errors <= 10) begin
            $display("%0t: %s", $realtime, what);
        end
    endfunction

    function void note_access(action_t act, logic [ADDR_W-1:0] addr, logic [BYTE_W-1:0] data);
        bus_result_t r;
        r.kind     = KIND_WRITE;
        r.rom_addr = '0;
        r.rd_byte  = '0;
        if (act == ACT_WRITE) begin
            case (region_t'(addr[15:13]))
                RGN_RAMG: ram_on = (data[3:0] == RAM_ENABLE_CODE);
                RGN_BANK1: begin
                    if (mode == MODE_ROM) begin
                        rom_bank = select_bank({upper_bits, data[4:0]});
                    end else begin
                        rom_bank = select_bank({2'b00, data[4:0]});
                    end
                end
                RGN_BANK2: begin
                    if (mode == MODE_ROM) begin
                        upper_bits = data[1:0];
                        rom_bank   = select_bank({data[1:0], rom_bank[4:0]});
                    end else begin
                        ram_bank = data[1:0] & ram_mask;
                    end
                end
                RGN_MODE: begin
                    if (data == MODE_SEL_ROM) begin
                        mode = MODE_ROM;
                    end else if (data == MODE_SEL_RAM) begin
                        mode = MODE_RAM;
                    end
                end
                RGN_XRAM: begin
                    if (ram_on) begin
                        ram_bytes[ram_slot(addr)]   = data;
                        ram_written[ram_slot(addr)] = 1'b1;
                    end
                end
                default: ;
            endcase
        end else begin
            case (region_t'(addr[15:13]))
                RGN_RAMG, RGN_BANK1: begin
                    r.kind     = KIND_ROM;
                    r.rom_addr = ROM_ADDR_W'(addr);
                end
                RGN_BANK2, RGN_MODE: begin
                    r.kind     = KIND_ROM;
                    r.rom_addr = {rom_bank, addr[ROM_OFF_W-1:0]};
                end
                RGN_XRAM: begin
                    r.kind    = KIND_DATA;
                    r.rd_byte = ram_on ? ram_bytes[ram_slot(addr)] : RAM_OFF_DATA;
                end
                default: r.kind = KIND_UNMAPPED;
            endcase
        end
        pending.push_back(r);
    endfunction

    function void check_result(kind_t got_kind, logic [ROM_ADDR_W-1:0] got_rom,
                               logic [BYTE_W-1:0] got_byte);
        bus_result_t want;
        if (pending.size() == 0) begin
            mismatch($sformatf("result word with none expected: kind %0d rom %h byte %h",
                               got_kind, got_rom, got_byte));
            return;
        end
        want = pending.pop_front();
        kind_count[want.kind]++;
        if (got_kind !== want.kind) begin
            mismatch($sformatf("kind: expected %0d, got %0d", want.kind, got_kind));
        end
        if (got_rom !== want.rom_addr) begin
            mismatch($sformatf("rom_address: expected %h, got %h", want.rom_addr, got_rom));
        end
        if (got_byte !== want.rd_byte) begin
            mismatch($sformatf("read_data: expected %h, got %h", want.rd_byte, got_byte));
        end
    endfunction
endclass

module cartridge_bank_controller_top_tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_WORDS = 160;
    localparam int PHASES      = 5;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [0:0]           s_tuser  = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [1:0]           m_tuser;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [PADDR_W-1:0]   paddr    = '0;
    logic [PDATA_W-1:0]   pwdata   = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    cartridge_shadow shadow = new();
    int send_idle_pct = 23;
    int recv_idle_pct = 76;
    int cycles = 0;
    int words_sent = 0;

    cartridge_bank_controller_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("cartridge_bank_controller_top test failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            shadow.check_result(kind_t'(m_tuser), m_tdata[ROM_ADDR_W-1:0],
                                m_tdata[ROM_ADDR_W+BYTE_W-1:ROM_ADDR_W]);
        end
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_word(action_t act, logic [ADDR_W-1:0] addr, logic [BYTE_W-1:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        // turn a read of unwritten RAM into a write of that byte
        if (!shadow.read_is_safe(act, addr)) begin
            act = ACT_WRITE;
        end
        s_tdata  <= {data, addr};
        s_tuser  <= act;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        shadow.note_access(act, addr, data);
        words_sent++;
    endtask

    function automatic logic [RAM_OFF_W-1:0] ram_offset(int hot_pct);
        if ($urandom_range(99) < hot_pct) begin
            return $urandom_range(1) ? 13'($urandom_range(15)) : 13'h1FF0 + 13'($urandom_range(15));
        end
        return 13'($urandom_range(16'h1FFF));
    endfunction

    task automatic random_word();
        int                pick;
        action_t           act;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
        pick = $urandom_range(99);
        act  = ACT_WRITE;
        addr = 16'($urandom_range(16'hFFFF));
        data = 8'($urandom_range(255));
        if (pick < 10) begin
            addr = 16'($urandom_range(16'h1FFF));
            if ($urandom_range(1)) data[3:0] = RAM_ENABLE_CODE;
        end else if (pick < 20) begin
            addr = 16'h2000 + 16'($urandom_range(16'h1FFF));
        end else if (pick < 28) begin
            addr = 16'h4000 + 16'($urandom_range(16'h1FFF));
        end else if (pick < 34) begin
            addr = 16'h6000 + 16'($urandom_range(16'h1FFF));
            if ($urandom_range(3) != 0) data = 8'($urandom_range(1));
        end else if (pick < 50) begin
            addr = {RGN_XRAM, ram_offset(60)};
        end else if (pick < 70) begin
            act  = ACT_READ;
            addr = 16'($urandom_range(16'h7FFF));
        end else if (pick < 85) begin
            act  = ACT_READ;
            addr = {RGN_XRAM, ram_offset(85)};
        end else if (pick < 93) begin
            act  = ACT_READ;
            addr = $urandom_range(1) ? 16'h8000 + 16'($urandom_range(16'h1FFF))
                                     : 16'hC000 + 16'($urandom_range(16'h3FFF));
        end else begin
            act = action_t'($urandom_range(1));
        end
        send_word(act, addr, data);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (shadow.pending.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic cfg_write(cfg_reg_t idx, logic [PDATA_W-1:0] value);
        logic [PDATA_W-1:0] want;
        want = (idx == CFG_ROM_MASK) ? PDATA_W'(value[ROM_BANK_W-1:0])
                                     : PDATA_W'(value[RAM_BANK_W-1:0]);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        shadow.set_mask(idx, value);
        @(posedge aclk);
        // read back
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata !== want) begin
            shadow.mismatch($sformatf("register %0d: expected %h, got %h", idx, want, prdata));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        logic [ROM_BANK_W-1:0] rom_masks [PHASES];
        logic [RAM_BANK_W-1:0] ram_masks [PHASES];
        int                    n;
        rom_masks = '{7'h7F, 7'h00, 7'h1F, 7'($urandom_range(127)), 7'h07};
        ram_masks = '{2'h3, 2'h0, 2'h1, 2'($urandom_range(3)), 2'h2};
        n = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_word(ACT_READ,  16'h0000, 8'h00);
        send_word(ACT_READ,  16'h3FFF, 8'hFF);
        send_word(ACT_READ,  16'h4000, 8'h00);
        send_word(ACT_READ,  16'h7FFF, 8'h00);
        send_word(ACT_READ,  16'h8000, 8'h00);
        send_word(ACT_READ,  16'hFFFF, 8'h00);
        send_word(ACT_READ,  16'hA000, 8'h00);
        send_word(ACT_WRITE, 16'h0000, 8'h0A);
        send_word(ACT_WRITE, 16'hA000, 8'h5A);
        send_word(ACT_WRITE, 16'hBFFF, 8'hFF);
        send_word(ACT_READ,  16'hA000, 8'h00);
        send_word(ACT_READ,  16'hBFFF, 8'h00);
        send_word(ACT_WRITE, 16'h2000, 8'h00);
        send_word(ACT_WRITE, 16'h3FFF, 8'hFF);
        send_word(ACT_WRITE, 16'h4000, 8'h03);
        send_word(ACT_READ,  16'h7FFF, 8'h00);
        send_word(ACT_WRITE, 16'h2000, 8'h20);
        send_word(ACT_WRITE, 16'h6000, MODE_SEL_RAM);
        send_word(ACT_WRITE, 16'h7FFF, 8'h02);
        send_word(ACT_WRITE, 16'h5FFF, 8'h02);
        send_word(ACT_WRITE, 16'hA123, 8'h33);
        send_word(ACT_READ,  16'hA123, 8'h00);
        send_word(ACT_WRITE, 16'h8000, 8'hAA);
        send_word(ACT_WRITE, 16'h1FFF, 8'h0B);
        send_word(ACT_READ,  16'hA000, 8'h00);
        send_word(ACT_WRITE, 16'h6000, MODE_SEL_ROM);

        for (int p = 0; p < PHASES; p++) begin
            drain();
            cfg_write(CFG_ROM_MASK, PDATA_W'(rom_masks[p]));
            cfg_write(CFG_RAM_MASK, PDATA_W'(ram_masks[p]));
            for (int i = 0; i < PHASE_WORDS; i++) begin
                if (n < 267) begin
                    send_idle_pct = 23;
                    recv_idle_pct = 76;
                end else if (n < 534) begin
                    send_idle_pct = 76;
                    recv_idle_pct = 23;
                end else begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                // hold the stream until every result is back
                if (n == 400) drain();
                random_word();
                n++;
            end
        end
        drain();
        repeat (10) @(posedge aclk);

        $display("Sent %0d bus access words over %0d mask settings with stalls on both sides",
                 words_sent, PHASES + 1);
        $display("Results: %0d writes, %0d ROM reads, %0d RAM reads, %0d unmapped; %0d errors",
                 shadow.kind_count[KIND_WRITE], shadow.kind_count[KIND_ROM],
                 shadow.kind_count[KIND_DATA], shadow.kind_count[KIND_UNMAPPED], shadow.errors);
        if (shadow.errors == 0 && shadow.pending.size() == 0) begin
            $display("cartridge_bank_controller_top test passed");
        end else begin
            $display("cartridge_bank_controller_top test failed");
        end
        $finish;
    end

endmodule
